@@ src/region_interval_lookup_top_macros.svh @@
// Assertion macros used by the checker file.
`ifndef REGION_INTERVAL_LOOKUP_TOP_MACROS_SVH
`define REGION_INTERVAL_LOOKUP_TOP_MACROS_SVH

// Check a condition in the same cycle as its trigger, outside reset.
`define RIL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("region lookup check failed");

// Check a condition in the cycle after its trigger, outside reset.
`define RIL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("region lookup check failed");

`endif

@@ src/ril_pkg.sv @@
package ril_pkg;

  // Field widths
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned MARGIN_W = 8;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned POS_W    = 33;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd30;

  // Item kinds on the input stream
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic append;
    logic query;
    logic scan;
    logic load_out;
  } ril_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
    logic miss;
    logic out_free;
  } ril_status_t;

endpackage

@@ src/region_interval_lookup_top.sv @@
// Clear and append are done in idle; a new item is taken the next cycle.
// A query scans the table from index 0, reading one region per cycle, and stops at the first
// hit or at the end of the table; no new item is taken until its result is loaded into the
// output register, and a result still waiting on m_tready delays the load.
// Reset (rst, synchronous) empties the table, sets margin to 30 and drops any
// pending result; table contents are not cleared and need no clearing pass.
module region_interval_lookup_top #(
  parameter int unsigned MAX_REGIONS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,  // region_offset[31:0], region_length[63:32], location[95:64]
  input  logic [1:0]  s_tuser,  // mode[1:0]
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // region_index[9:0], position[42:10], zero[47:43]
  output logic        m_tuser,  // found[0]
  // Margin register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  import ril_pkg::*;

  ril_cmd_t                 cmd;
  ril_status_t              status;
  logic [IDX_W-1:0]         region_index;
  logic signed [POS_W-1:0]  position;

  assign cfg_ready = 1'b1;

  ril_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .mode     (s_tuser),
    .cmd      (cmd),
    .status   (status)
  );

  ril_dp #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_margin    (cfg_data),
    .region_offset (s_tdata[31:0]),
    .region_length (s_tdata[63:32]),
    .location      ($signed(s_tdata[95:64])),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .found         (m_tuser),
    .region_index  (region_index),
    .position      (position)
  );

  // Pack the result fields, highest field first
  assign m_tdata = {5'b00000, position, region_index};

endmodule

@@ src/ril_ram.sv @@
module ril_ram #(
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/ril_ctrl.sv @@
module ril_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ril_pkg::MODE_W-1:0] mode,
  output ril_pkg::ril_cmd_t          cmd,
  input  ril_pkg::ril_status_t       status
);

  import ril_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } ril_state_t;

  ril_state_t state;
  ril_state_t state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (mode)
            MODE_CLEAR:  cmd.clear  = 1'b1;
            MODE_APPEND: cmd.append = 1'b1;
            MODE_QUERY: begin
              cmd.query  = 1'b1;
              state_next = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.hit || status.miss) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ src/ril_dp.sv @@
module ril_dp #(
  parameter int unsigned MAX_REGIONS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ril_pkg::ril_cmd_t             cmd,
  output ril_pkg::ril_status_t          status,
  input  logic                          cfg_we,
  input  logic [ril_pkg::MARGIN_W-1:0]  cfg_margin,
  input  logic [ril_pkg::DATA_W-1:0]    region_offset,
  input  logic [ril_pkg::DATA_W-1:0]    region_length,
  input  logic signed [ril_pkg::DATA_W-1:0] location,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic [ril_pkg::IDX_W-1:0]     region_index,
  output logic signed [ril_pkg::POS_W-1:0] position
);

  import ril_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_REGIONS + 1);
  localparam int unsigned AW  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned IXW = (AW > IDX_W) ? AW : IDX_W;

  logic [MARGIN_W-1:0]   margin;
  logic [CW-1:0]         count;
  logic                  full;

  // Query operands
  logic                  neg;
  logic [DATA_W-2:0]     mag_now;
  logic [DATA_W:0]       mag_hi;
  logic [DATA_W:0]       mag_lo;
  logic [DATA_W-1:0]     magp1;

  // Scan pointer and read pipeline
  logic [CW-1:0]         addr;
  logic                  issue;
  logic                  rd_valid;
  logic [AW-1:0]         rd_idx;
  logic [2*DATA_W-1:0]   rdata;
  logic [DATA_W-1:0]     rd_off;
  logic [DATA_W-1:0]     rd_len;
  logic [DATA_W:0]       rd_end;
  logic                  match;

  // Captured hit
  logic                  hit_found;
  logic [AW-1:0]         hit_idx;
  logic [DATA_W-1:0]     hit_off;
  logic [IXW-1:0]        hit_idx_ext;
  logic [DATA_W+1:0]     pos_wide;

  assign full = (count == CW'(MAX_REGIONS));

  // Magnitude of the location, most negative value saturated
  always_comb begin
    if (location[DATA_W-1]) begin
      if (location == {1'b1, {(DATA_W-1){1'b0}}}) begin
        mag_now = '1;
      end else begin
        mag_now = (DATA_W-1)'(-location);
      end
    end else begin
      mag_now = location[DATA_W-2:0];
    end
  end

  // Region table
  ril_ram #(
    .WIDTH (2*DATA_W),
    .DEPTH (MAX_REGIONS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.append && !full),
    .waddr (count[AW-1:0]),
    .wdata ({region_length, region_offset}),
    .re    (issue),
    .raddr (addr[AW-1:0]),
    .rdata (rdata)
  );

  assign issue  = cmd.scan && (addr != count);
  assign rd_off = rdata[DATA_W-1:0];
  assign rd_len = rdata[2*DATA_W-1:DATA_W];
  assign rd_end = {1'b0, rd_off} + {1'b0, rd_len};

  // Widened overlap test against the entry just read
  assign match = ({1'b0, rd_off} < mag_hi) &&
                 ($signed({mag_lo[DATA_W], mag_lo}) < $signed({1'b0, rd_end}));

  assign status.hit      = cmd.scan && rd_valid && match;
  assign status.miss     = cmd.scan && !rd_valid && (addr == count);
  assign status.out_free = !out_valid || out_ready;

  // Control state: margin, fill count, read pipeline, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      margin    <= MARGIN_RESET;
      count     <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        margin <= cfg_margin;
      end
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.append && !full) begin
        count <= count + 1'b1;
      end
      if (cmd.query) begin
        rd_valid <= 1'b0;
      end else if (cmd.scan) begin
        rd_valid <= issue;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Query operands and scan pointer
  always_ff @(posedge clk) begin
    if (cmd.query) begin
      neg    <= location[DATA_W-1];
      mag_hi <= (DATA_W+1)'(mag_now) + (DATA_W+1)'(margin);
      mag_lo <= (DATA_W+1)'(mag_now) - (DATA_W+1)'(margin);
      magp1  <= DATA_W'(mag_now) + 1'b1;
      addr   <= '0;
    end else if (issue) begin
      addr   <= addr + 1'b1;
    end
    if (issue) begin
      rd_idx <= addr[AW-1:0];
    end
  end

  // Hold the first hit, or mark a miss
  always_ff @(posedge clk) begin
    if (status.hit) begin
      hit_found <= 1'b1;
      hit_idx   <= rd_idx;
      hit_off   <= rd_off;
    end else if (status.miss) begin
      hit_found <= 1'b0;
    end
  end

  assign hit_idx_ext = IXW'(hit_idx);
  assign pos_wide    = neg ? ({2'b00, hit_off} - {2'b00, magp1})
                           : ({2'b00, magp1} - {2'b00, hit_off});

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      found        <= hit_found;
      region_index <= hit_found ? hit_idx_ext[IDX_W-1:0] : '0;
      position     <= hit_found ? $signed(pos_wide[POS_W-1:0]) : '0;
    end
  end

endmodule

@@ src/ril_checker.sv @@
`include "region_interval_lookup_top_macros.svh"

module ril_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser
);

  // A stalled result stays offered
  `RIL_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)

  // A stalled result keeps its payload
  `RIL_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

  // A miss carries zero index and zero position
  `RIL_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tuser, m_tdata == 48'd0)

  // No result is offered right after reset
  `RIL_ASSERT_NOW(a_reset_empty, $past(rst), !m_tvalid)

endmodule

bind region_interval_lookup_top ril_checker u_ril_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ dv/tb_region_interval_lookup_top.sv @@
`timescale 1ns / 1ps

module tb_region_interval_lookup_top;
  import ril_pkg::*;

  localparam int unsigned TABLE_DEPTH   = 1024;
  localparam int unsigned FILL_COUNT    = 150;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES = TABLE_DEPTH + 16;
  localparam int unsigned CFG_PAUSE     = 8;

  // Mode value the block ignores
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] roff;
    logic [DATA_W-1:0] rlen;
    logic [DATA_W-1:0] loc;
    bit                drain;
  } region_op_t;

  typedef struct {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] pos;
  } lookup_t;

  logic                clk;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [95:0]         s_tdata   = '0;  // region_offset[31:0], region_length[63:32], location[95:64]
  logic [1:0]          s_tuser   = '0;  // mode[1:0]
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [47:0]         m_tdata;         // region_index[9:0], position[42:10], zero[47:43]
  logic                m_tuser;         // found[0]
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [MARGIN_W-1:0] cfg_data  = '0;

  region_interval_lookup_top #(
    .MAX_REGIONS(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Operations waiting to be sent and lookups waiting to come back
  region_op_t op_queue[$];
  lookup_t    pending_lookups[$];

  // Predicted table and margin
  logic [DATA_W-1:0]   table_off [TABLE_DEPTH];
  logic [DATA_W-1:0]   table_len [TABLE_DEPTH];
  int unsigned         table_count;
  logic [MARGIN_W-1:0] margin_now;

  // Table contents as seen by the stimulus generator
  logic [DATA_W-1:0]   plan_off[$];
  logic [DATA_W-1:0]   plan_len[$];
  logic [MARGIN_W-1:0] plan_margin = MARGIN_RESET;

  bit          op_taken;
  int unsigned errors;
  int unsigned quiet_cycles;
  int unsigned burst_left;
  int unsigned gap_left;
  bit          send_idle;
  bit          recv_idle;
  logic [7:0]  ready_pattern = 8'hFF;
  int unsigned pattern_age;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // First region whose margin-widened span covers |loc|; position carries the sign of loc
  function automatic lookup_t predict_lookup(input logic [DATA_W-1:0] loc);
    lookup_t          r;
    logic             neg;
    logic [DATA_W-1:0] m;
    longint           mag, mg, off, len, p;
    r = '{found: 1'b0, idx: '0, pos: '0};
    neg = loc[DATA_W-1];
    m = neg ? (~loc + 1'b1) : loc;
    if (m > 32'h7FFF_FFFF) m = 32'h7FFF_FFFF;
    mag = longint'(m);
    mg = longint'(margin_now);
    for (int unsigned k = 0; k < table_count; k++) begin
      off = longint'(table_off[k]);
      len = longint'(table_len[k]);
      if (off < mag + mg && mag - mg < off + len) begin
        p = mag + 1 - off;
        if (neg) p = -p;
        r.found = 1'b1;
        r.idx = IDX_W'(k);
        r.pos = p[POS_W-1:0];
        return r;
      end
    end
    return r;
  endfunction

  // Update the predicted table for one accepted transaction
  function automatic void apply_op(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] roff,
                                   input logic [DATA_W-1:0] rlen, input logic [DATA_W-1:0] loc);
    case (mode)
      MODE_CLEAR: begin
        table_count = 0;
      end
      MODE_APPEND: begin
        if (table_count < TABLE_DEPTH) begin
          table_off[table_count] = roff;
          table_len[table_count] = rlen;
          table_count++;
        end
      end
      MODE_QUERY: begin
        pending_lookups.push_back(predict_lookup(loc));
      end
      default: ;
    endcase
  endfunction

  // Queue one operation and track what the table will hold
  function automatic void queue_region_op(input logic [MODE_W-1:0] mode,
                                          input logic [DATA_W-1:0] roff,
                                          input logic [DATA_W-1:0] rlen,
                                          input logic [DATA_W-1:0] loc,
                                          input bit drain = 1'b0);
    region_op_t op;
    op = '{mode: mode, roff: roff, rlen: rlen, loc: loc, drain: drain};
    op_queue.push_back(op);
    if (mode == MODE_CLEAR) begin
      plan_off.delete();
      plan_len.delete();
    end else if (mode == MODE_APPEND && plan_off.size() < TABLE_DEPTH) begin
      plan_off.push_back(roff);
      plan_len.push_back(rlen);
    end
  endfunction

  function automatic void queue_random_region(input int unsigned span);
    logic [DATA_W-1:0] off, len;
    off = $urandom_range(0, span);
    len = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 400);
    queue_region_op(MODE_APPEND, off, len, $urandom());
  endfunction

  // Pick a location inside or at the widened edges of a stored region, sometimes anywhere
  function automatic logic [DATA_W-1:0] pick_location();
    longint            t, d, off, len, mg;
    int unsigned       k;
    logic [DATA_W-1:0] loc;
    if (plan_off.size() == 0 || $urandom_range(0, 9) == 0) begin
      loc = $urandom();
      if ($urandom_range(0, 15) == 0) loc = 32'h8000_0000;
      return loc;
    end
    mg = longint'(plan_margin);
    k = $urandom_range(0, plan_off.size() - 1);
    off = longint'(plan_off[k]);
    len = longint'(plan_len[k]);
    d = $urandom_range(0, 4);
    case ($urandom_range(0, 4))
      0: t = off + longint'($urandom()) % (len + 1);
      1: t = off - mg - 2 + d;
      2: t = off + len + mg - 2 + d;
      3: t = off + len - 1;
      default: t = off;
    endcase
    if (t < 0) t = 0;
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    loc = DATA_W'(t);
    if ($urandom_range(0, 1) == 1) loc = ~loc + 1'b1;
    return loc;
  endfunction

  task automatic wait_drained();
    @(posedge clk);
    while (op_queue.size() != 0 || s_tvalid || pending_lookups.size() != 0) @(posedge clk);
  endtask

  // Write the margin while the block is idle
  task automatic write_margin(input logic [MARGIN_W-1:0] value);
    wait_drained();
    repeat (CFG_PAUSE) @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    plan_margin = value;
  endtask

  task automatic random_phase(input int unsigned n_ops, input int unsigned span,
                              input bit idle_on);
    int unsigned r;
    send_idle = idle_on;
    recv_idle = idle_on;
    queue_region_op(MODE_CLEAR, $urandom(), $urandom(), $urandom());
    repeat ($urandom_range(1, 24)) queue_random_region(span);
    for (int unsigned i = 0; i < n_ops; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55)
        queue_region_op(MODE_QUERY, $urandom(), $urandom(), pick_location(),
                        $urandom_range(0, 39) == 0);
      else if (r < 82)
        queue_random_region(span);
      else if (r < 85)
        queue_region_op(MODE_CLEAR, $urandom(), $urandom(), $urandom());
      else if (r < 90)
        queue_region_op(MODE_UNUSED, $urandom(), $urandom(), $urandom());
      else if (r < 94)
        queue_region_op(MODE_APPEND, $urandom(), $urandom(), $urandom());
      else
        queue_region_op(MODE_QUERY, $urandom(), $urandom(), $urandom());
    end
  endtask

  // Sample handshakes, predict, check results and watch for a hang
  always @(posedge clk) begin
    lookup_t want;
    bit      moved;
    if (rst) begin
      op_taken = 1'b0;
      quiet_cycles = 0;
      table_count = 0;
      margin_now = MARGIN_RESET;
    end else begin
      op_taken = s_tvalid && s_tready;
      moved = op_taken;
      if (op_taken) apply_op(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]);
      if (cfg_valid && cfg_ready) begin
        margin_now = cfg_data;
        moved = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        if (pending_lookups.size() == 0) begin
          $display("%0t: result with no query pending: expected none, actual found=%0b index=%0d",
                   $time, m_tuser, m_tdata[9:0]);
          errors++;
        end else begin
          want = pending_lookups.pop_front();
          if (m_tuser !== want.found) begin
            $display("%0t: found mismatch: expected %0b, actual %0b", $time, want.found, m_tuser);
            errors++;
          end
          if (m_tdata[9:0] !== want.idx) begin
            $display("%0t: region_index mismatch: expected %0d, actual %0d",
                     $time, want.idx, m_tdata[9:0]);
            errors++;
          end
          if (m_tdata[42:10] !== want.pos) begin
            $display("%0t: position mismatch: expected %0d, actual %0d",
                     $time, $signed(want.pos), $signed(m_tdata[42:10]));
            errors++;
          end
          if (m_tdata[47:43] !== 5'd0) begin
            $display("%0t: pad bits mismatch: expected 0, actual %0h", $time, m_tdata[47:43]);
            errors++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Drive the input stream in bursts and the result ready on its own pattern
  always @(negedge clk) begin
    region_op_t op;
    bit         launch;
    if (rst !== 1'b0) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
      burst_left = 1;
      gap_left = 0;
      pattern_age = 0;
    end else begin
      if (!s_tvalid || op_taken) begin
        launch = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (op_queue.size() != 0 &&
                     !(op_queue[0].drain && pending_lookups.size() != 0)) begin
          op = op_queue.pop_front();
          launch = 1'b1;
          s_tuser <= op.mode;
          s_tdata <= {op.loc, op.rlen, op.roff};
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = (send_idle && $urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : 0;
          end
        end
        s_tvalid <= launch;
      end
      // Reload the stall pattern now and then, rotate it every cycle
      if (recv_idle) begin
        if (pattern_age == 0) begin
          ready_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom());
          pattern_age = $urandom_range(8, 64);
        end else begin
          pattern_age--;
        end
        ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
        m_tready <= ready_pattern[0];
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    errors = 0;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed checks at the reset margin, no idling
    queue_region_op(MODE_QUERY, '0, '0, 32'd5);
    queue_region_op(MODE_APPEND, 32'd100, 32'd50, '0);
    queue_region_op(MODE_QUERY, '0, '0, 32'd100);
    queue_region_op(MODE_QUERY, '0, '0, -32'sd120);
    queue_region_op(MODE_QUERY, '0, '0, 32'd0);
    queue_region_op(MODE_QUERY, '0, '0, 32'd70);
    queue_region_op(MODE_QUERY, '0, '0, 32'd71);
    queue_region_op(MODE_QUERY, '0, '0, 32'd179);
    queue_region_op(MODE_QUERY, '0, '0, 32'd180);
    queue_region_op(MODE_APPEND, 32'd0, 32'd0, '1);
    queue_region_op(MODE_QUERY, '1, '1, 32'd0);
    queue_region_op(MODE_APPEND, '1, '1, '0);
    queue_region_op(MODE_APPEND, '0, '1, '0);
    queue_region_op(MODE_QUERY, '0, '0, 32'h8000_0000);
    queue_region_op(MODE_QUERY, '0, '0, 32'h7FFF_FFFF);
    queue_region_op(MODE_QUERY, '0, '0, 32'h8000_0001);
    queue_region_op(MODE_UNUSED, '1, '1, '1);
    queue_region_op(MODE_UNUSED, 32'd5, 32'd5, 32'd110);
    queue_region_op(MODE_QUERY, '0, '0, 32'd110);
    queue_region_op(MODE_CLEAR, '1, '1, '1);
    queue_region_op(MODE_QUERY, '0, '0, 32'd110, 1'b1);
    queue_region_op(MODE_APPEND, '1, 32'd0, '0);
    queue_region_op(MODE_QUERY, '0, '0, 32'h7FFF_FFFF);

    // Load a long table of disjoint regions, zero margin
    write_margin(8'd0);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    queue_region_op(MODE_CLEAR, '0, '0, '0);
    for (int unsigned k = 0; k < FILL_COUNT; k++)
      queue_region_op(MODE_APPEND, k * 1000 + $urandom_range(0, 100), $urandom_range(0, 800),
                      $urandom());
    repeat (20) queue_region_op(MODE_QUERY, $urandom(), $urandom(), pick_location());
    queue_region_op(MODE_QUERY, '0, '0, (FILL_COUNT + 3) * 1000 + 400, 1'b1);

    // Random phases over a spread of margins and spans
    write_margin(8'd255);
    random_phase(64, 20000, 1'b1);
    write_margin(8'($urandom_range(1, 254)));
    random_phase(64, 5000, 1'b1);
    write_margin(MARGIN_RESET);
    random_phase(64, 32'h7FFF_FFFF, 1'b0);
    write_margin(8'd1);
    random_phase(64, 3000, 1'b1);
    write_margin(8'($urandom_range(1, 254)));
    random_phase(64, 1000, 1'b1);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/ril_pkg.sv
src/ril_ram.sv
src/ril_ctrl.sv
src/ril_dp.sv
src/region_interval_lookup_top.sv
src/ril_checker.sv
dv/tb_region_interval_lookup_top.sv
